FILE: design/chm_pkg.sv
// shared types and constants for the grown convex hull measure
`timescale 1ns / 1ps
package chm_pkg;

  localparam int COORD_W     = 16;
  localparam int R_W         = 16;
  localparam int PERIM_W     = 36;
  localparam int AREA_W      = 52;
  localparam int VERT_W      = 11;
  localparam int QUEUE_DEPTH = 4;
  // squared edge length and its fixed point root
  localparam int D2_W        = 2 * COORD_W + 3;
  localparam int SQ_W        = (D2_W + 33) / 2;

  // pi with 40 fraction bits, split in two halves for the multiplier
  localparam logic [41:0] PI40  = 42'd3454217652358;
  localparam logic [20:0] PI_LO = PI40[20:0];
  localparam logic [20:0] PI_HI = PI40[41:21];

  localparam logic [PERIM_W-1:0] PERIM_MAX = {PERIM_W{1'b1}};
  localparam logic [AREA_W-1:0]  AREA_MAX  = {AREA_W{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } in_item_t;

  typedef struct packed {
    logic [PERIM_W-1:0] grown_perimeter;
    logic [AREA_W-1:0]  grown_area;
    logic [VERT_W-1:0]  hull_vertices;
    logic               overflow;
  } result_t;

endpackage

FILE: design/chm_front.sv
// input side: takes point beats into a short queue ahead of the compute engine
`timescale 1ns / 1ps
module chm_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  chm_pkg::in_item_t item,
  output chm_pkg::in_item_t head,
  output logic             head_valid,
  input  logic             pop
);
  import chm_pkg::*;

  localparam int QA = $clog2(QUEUE_DEPTH);

  in_item_t         q [QUEUE_DEPTH];
  logic [QA-1:0]    wr_ptr;
  logic [QA-1:0]    rd_ptr;
  logic [QA:0]      count;
  logic             push;
  logic             take;

  assign busy       = (count == (QA + 1)'(QUEUE_DEPTH));
  assign push       = start && !busy;
  assign head_valid = (count != '0);
  assign take       = pop && head_valid;
  assign head       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/chm_sqrt.sv
// digit by digit square root: floor(sqrt(d2) * 2^16), one result bit per cycle
`timescale 1ns / 1ps
module chm_sqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [chm_pkg::D2_W-1:0] radicand,
  output logic                     done,
  output logic [chm_pkg::SQ_W-1:0] root
);
  import chm_pkg::*;

  localparam int XW = 2 * SQ_W;
  localparam int CNT_W = $clog2(SQ_W + 1);

  logic [XW-1:0]     x;
  logic [SQ_W+1:0]   rem;
  logic [CNT_W-1:0]  cnt;
  logic              active;
  logic [SQ_W+3:0]   rem_sh;
  logic [SQ_W+3:0]   trial;

  assign rem_sh = {rem, x[XW-1 -: 2]};
  assign trial  = (SQ_W + 4)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
      end else if (active && cnt == CNT_W'(1)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x    <= XW'({radicand, 32'b0});
      rem  <= '0;
      root <= '0;
      cnt  <= CNT_W'(SQ_W);
    end else if (active) begin
      x   <= x << 2;
      cnt <= cnt - 1'b1;
      if (rem_sh >= trial) begin
        rem  <= (SQ_W + 2)'(rem_sh - trial);
        root <= {root[SQ_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[SQ_W+1:0];
        root <= {root[SQ_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: design/chm_back.sv
// compute engine: point store, sort, monotone chain hull, perimeter and area
`timescale 1ns / 1ps
module chm_back #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  chm_pkg::in_item_t       q_item,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  logic [chm_pkg::R_W-1:0] radius,
  output chm_pkg::result_t        result,
  output logic                    done
);
  import chm_pkg::*;

  localparam int PA     = $clog2(MAX_POINTS);
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int HDEPTH = MAX_POINTS + 1;
  localparam int HA     = $clog2(HDEPTH);
  localparam int MW     = $clog2(MAX_POINTS + 2);
  localparam int DW     = COORD_W + 1;
  localparam int PW     = SQ_W + MW;
  localparam int TW     = 2 * COORD_W + 2 + MW;
  localparam int AW     = PW + R_W + 2;

  typedef enum logic [25:0] {
    S_LOAD = 26'h0000001,
    S_SI   = 26'h0000002,
    S_SP   = 26'h0000004,
    S_SC   = 26'h0000008,
    S_SW   = 26'h0000010,
    S_D0   = 26'h0000020,
    S_DR   = 26'h0000040,
    S_DC   = 26'h0000080,
    S_HR   = 26'h0000100,
    S_HP   = 26'h0000200,
    S_HT   = 26'h0000400,
    S_HC   = 26'h0000800,
    S_HL   = 26'h0001000,
    S_M0   = 26'h0002000,
    S_M1   = 26'h0004000,
    S_MR   = 26'h0008000,
    S_MB   = 26'h0010000,
    S_MS   = 26'h0020000,
    S_MW   = 26'h0040000,
    S_F0   = 26'h0080000,
    S_F1   = 26'h0100000,
    S_F2   = 26'h0200000,
    S_F3   = 26'h0400000,
    S_F4   = 26'h0800000,
    S_F5   = 26'h1000000,
    S_F6   = 26'h2000000
  } state_t;

  state_t state;

  point_t pts [MAX_POINTS];
  point_t hs  [HDEPTH];
  point_t pts_q, hs_q;

  logic          pw_en, hw_en;
  logic [PA-1:0] pw_addr, pr_addr;
  logic [HA-1:0] hw_addr, hr_addr;
  point_t        pw_data, hw_data;

  logic [CW-1:0] cnt, n, j;
  logic          ovf;
  logic [MW-1:0] i, k, m;
  logic          upper;
  point_t        p, last, t1, t2, a_pt;

  logic signed [2*DW-1:0]    mul1, mul2, dxx, dyy;
  logic signed [2*COORD_W-1:0] xy1, xy2;
  logic [PW-1:0]             per, pterm;
  logic signed [TW-1:0]      twice;
  logic [TW-1:0]             tabs;
  logic [2*R_W-1:0]          rr;
  logic [R_W+20:0]           rpl, rph;
  logic [2*R_W+20:0]         prl, prh;
  logic [R_W+31:0]           prlo;
  logic [PW-17:0]            prhi;
  logic [AW-1:0]             pr2, ppr, asum, asum2;
  logic [PW:0]               pfull;

  // helper arithmetic
  logic [MW-1:0]  im1, mm3, vfull;
  logic [CW-1:0]  jm2;
  logic           allow, lt, push_ok;
  logic signed [DW-1:0] ax, ay, bx, by, dx, dy;
  logic signed [2*COORD_W:0] xyd;
  logic [D2_W-1:0] d2;
  logic [R_W+41:0] rsum;
  logic [2*R_W+41:0] prsum;
  logic             sq_go, sq_done;
  logic [SQ_W-1:0]  sq_root;

  function automatic logic precedes(point_t a, point_t b);
    return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction

  assign im1     = i - 1'b1;
  assign mm3     = m - 2'd3;
  assign jm2     = j - 2'd2;
  assign allow   = upper ? (m > k) : (m > MW'(1));
  assign lt      = precedes(p, pts_q);
  assign push_ok = !upper || (m < MW'(HDEPTH));
  assign ax      = DW'(t1.x) - DW'(t2.x);
  assign ay      = DW'(t1.y) - DW'(t2.y);
  assign bx      = DW'(p.x) - DW'(t2.x);
  assign by      = DW'(p.y) - DW'(t2.y);
  assign dx      = DW'(hs_q.x) - DW'(a_pt.x);
  assign dy      = DW'(hs_q.y) - DW'(a_pt.y);
  assign xyd     = xy1 - xy2;
  assign d2      = D2_W'($unsigned(dxx)) + D2_W'($unsigned(dyy));
  assign rsum    = {rph, 21'b0} + (R_W + 42)'(rpl);
  assign prsum   = {prh, 21'b0} + (2 * R_W + 42)'(prl);
  assign asum2   = asum + pr2;
  assign sq_go   = (state == S_MS);
  assign vfull   = (n == '0) ? '0 : ((n == CW'(1)) ? MW'(1) : (m - 1'b1));

  chm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .go       (sq_go),
    .radicand (d2),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_comb begin
    q_pop     = 1'b0;
    pw_en     = 1'b0;
    pw_addr   = cnt[PA-1:0];
    pw_data.x = q_item.point_x;
    pw_data.y = q_item.point_y;
    pr_addr   = i[PA-1:0];
    hw_en     = 1'b0;
    hw_addr   = m[HA-1:0];
    hw_data   = p;
    hr_addr   = i[HA-1:0];
    unique case (state)
      S_LOAD: begin
        q_pop = q_valid;
        pw_en = q_valid && (cnt < CW'(MAX_POINTS));
      end
      S_SI: begin
        if (i >= MW'(n)) begin
          pr_addr = '0;
        end
      end
      S_SP: pr_addr = im1[PA-1:0];
      S_SC: begin
        pw_en   = 1'b1;
        pw_addr = j[PA-1:0];
        pr_addr = jm2[PA-1:0];
        pw_data = lt ? pts_q : p;
      end
      S_SW: begin
        pw_en   = 1'b1;
        pw_addr = '0;
        pw_data = p;
      end
      S_DC: begin
        pw_en   = (pts_q != last);
        pw_addr = k[PA-1:0];
        pw_data = pts_q;
      end
      S_HR: begin
        if (upper) begin
          pr_addr = im1[PA-1:0];
        end
      end
      S_HT: hw_en = !allow && push_ok;
      S_HC: begin
        if (mul1 <= mul2) begin
          hr_addr = mm3[HA-1:0];
        end else begin
          hw_en = push_ok;
        end
      end
      S_M0:    hr_addr = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      pts[pw_addr] <= pw_data;
    end
    pts_q <= pts[pr_addr];
  end

  always_ff @(posedge clk) begin
    if (hw_en) begin
      hs[hw_addr] <= hw_data;
    end
    hs_q <= hs[hr_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt   <= '0;
      ovf   <= 1'b0;
      done  <= 1'b0;
      m     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (q_valid) begin
            if (cnt < CW'(MAX_POINTS)) begin
              cnt <= cnt + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            if (q_item.last_point) begin
              n     <= (cnt < CW'(MAX_POINTS)) ? cnt + 1'b1 : cnt;
              i     <= MW'(1);
              per   <= '0;
              twice <= '0;
              state <= S_SI;
            end
          end
        end
        // insertion sort by x then y
        S_SI: begin
          if (i >= MW'(n)) begin
            if (n == '0) begin
              i     <= '0;
              m     <= '0;
              upper <= 1'b0;
              state <= S_HR;
            end else begin
              state <= S_D0;
            end
          end else begin
            state <= S_SP;
          end
        end
        S_SP: begin
          p     <= pts_q;
          j     <= CW'(i);
          state <= S_SC;
        end
        S_SC: begin
          if (lt) begin
            j <= j - 1'b1;
            if (j == CW'(1)) begin
              state <= S_SW;
            end
          end else begin
            i     <= i + 1'b1;
            state <= S_SI;
          end
        end
        S_SW: begin
          i     <= i + 1'b1;
          state <= S_SI;
        end
        // merge duplicates
        S_D0: begin
          last  <= pts_q;
          i     <= MW'(1);
          k     <= MW'(1);
          state <= S_DR;
        end
        S_DR: begin
          if (i >= MW'(n)) begin
            n     <= CW'(k);
            i     <= '0;
            m     <= '0;
            upper <= 1'b0;
            state <= S_HR;
          end else begin
            state <= S_DC;
          end
        end
        S_DC: begin
          if (pts_q != last) begin
            k    <= k + 1'b1;
            last <= pts_q;
          end
          i     <= i + 1'b1;
          state <= S_DR;
        end
        // lower chain, then upper chain
        S_HR: begin
          if (!upper) begin
            if (i >= MW'(n)) begin
              k     <= m;
              upper <= 1'b1;
              i     <= (n > CW'(1)) ? MW'(n - 1'b1) : '0;
            end else begin
              state <= S_HP;
            end
          end else if (i == '0) begin
            state <= S_M0;
          end else begin
            state <= S_HP;
          end
        end
        S_HP: begin
          p     <= pts_q;
          state <= S_HT;
        end
        S_HT: begin
          if (allow) begin
            mul1  <= ax * by;
            mul2  <= ay * bx;
            state <= S_HC;
          end else begin
            if (push_ok) begin
              t2 <= t1;
              t1 <= p;
              m  <= m + 1'b1;
            end
            i     <= upper ? i - 1'b1 : i + 1'b1;
            state <= S_HR;
          end
        end
        S_HC: begin
          if (mul1 <= mul2) begin
            // pop: old second from top becomes top, refill second from store
            t1    <= t2;
            m     <= m - 1'b1;
            state <= S_HL;
          end else begin
            if (push_ok) begin
              t2 <= t1;
              t1 <= p;
              m  <= m + 1'b1;
            end
            i     <= upper ? i - 1'b1 : i + 1'b1;
            state <= S_HR;
          end
        end
        S_HL: begin
          t2    <= hs_q;
          state <= S_HT;
        end
        // walk hull edges
        S_M0: state <= (m < MW'(2)) ? S_F0 : S_M1;
        S_M1: begin
          a_pt  <= hs_q;
          i     <= MW'(1);
          state <= S_MR;
        end
        S_MR: state <= (i >= m) ? S_F0 : S_MB;
        S_MB: begin
          dxx   <= dx * dx;
          dyy   <= dy * dy;
          xy1   <= a_pt.x * hs_q.y;
          xy2   <= hs_q.x * a_pt.y;
          a_pt  <= hs_q;
          state <= S_MS;
        end
        S_MS: begin
          twice <= twice + TW'(xyd);
          state <= S_MW;
        end
        S_MW: begin
          if (sq_done) begin
            per   <= per + PW'(sq_root);
            i     <= i + 1'b1;
            state <= S_MR;
          end
        end
        // growth terms and saturation
        S_F0: begin
          tabs  <= twice[TW-1] ? TW'(-twice) : TW'(twice);
          rr    <= radius * radius;
          rpl   <= radius * PI_LO;
          rph   <= radius * PI_HI;
          state <= S_F1;
        end
        S_F1: begin
          prl   <= rr * PI_LO;
          pterm <= PW'(rsum[R_W+41:23]);
          state <= S_F2;
        end
        S_F2: begin
          prh   <= rr * PI_HI;
          prlo  <= per[31:0] * radius;
          state <= S_F3;
        end
        S_F3: begin
          pr2   <= AW'(prsum[2*R_W+41:24]);
          prhi  <= per[PW-1:32] * radius;
          state <= S_F4;
        end
        S_F4: begin
          pfull <= {1'b0, per} + {1'b0, pterm};
          ppr   <= AW'({prhi, 32'b0}) + AW'(prlo);
          state <= S_F5;
        end
        S_F5: begin
          asum  <= AW'({tabs, 15'b0}) + ppr;
          state <= S_F6;
        end
        S_F6: begin
          result.grown_perimeter <= (pfull > (PW + 1)'(PERIM_MAX)) ? PERIM_MAX
                                                                 : pfull[PERIM_W-1:0];
          result.grown_area      <= (asum2 > AW'(AREA_MAX)) ? AREA_MAX : asum2[AREA_W-1:0];
          result.hull_vertices   <= VERT_W'(vfull);
          result.overflow        <= ovf;
          done  <= 1'b1;
          cnt   <= '0;
          ovf   <= 1'b0;
          state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held more than one cycle");
  a_pop_load: assert property (@(posedge clk) disable iff (rst) q_pop |-> state == S_LOAD)
    else $error("queue popped outside load");
  a_stack_bound: assert property (@(posedge clk) disable iff (rst) m <= MW'(HDEPTH))
    else $error("hull stack beyond its depth");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      cnt <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

endmodule

FILE: design/convex_hull_offset_measure.sv
// top level: grown convex hull measure
//
// Points arrive as beats on point, taken when start is high and busy is low.
// A four entry queue sits in front of the compute engine, so busy rises only
// when that queue is full. A beat with last_point set closes the set; its
// result appears on result with done high for exactly one cycle, and the
// receiver cannot hold it off.
// offset_radius is loaded when offset_we is high; write it only while idle.
// Loading moves each point from the queue into the point memory. After the
// last point the engine runs an insertion sort in the point memory, a
// duplicate merge, the monotone chain scan, then the hull edges one at a
// time through the bit serial square root, and the finishing arithmetic.
// The sort in the point memory sets the time per set for large sets; the
// square root sets it for small ones.
// Reset empties the queue, zeroes the point count, overflow and radius; the
// point and hull memories are not cleared and are read only after writes.
`timescale 1ns / 1ps
module convex_hull_offset_measure #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  chm_pkg::in_item_t       point,
  input  logic                    offset_we,
  input  logic [chm_pkg::R_W-1:0] offset_radius,
  output logic                    done,
  output chm_pkg::result_t        result
);
  import chm_pkg::*;

  in_item_t       head;
  logic           head_valid;
  logic           pop;
  logic [R_W-1:0] radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
    end else if (offset_we) begin
      radius <= offset_radius;
    end
  end

  chm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (point),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  chm_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (head),
    .q_valid (head_valid),
    .q_pop   (pop),
    .radius  (radius),
    .result  (result),
    .done    (done)
  );

endmodule
